>>> design/nta_pkg.sv
// Shared types, constants and helper functions for the number to ASCII formatter.
// No dependencies; every other design file imports this package.
package nta_pkg;

	// Format selector codes
	typedef enum logic [1:0] {
		OP_DEC32 = 2'd0,
		OP_DEC16 = 2'd1,
		OP_HEX32 = 2'd2,
		OP_BIN16 = 2'd3
	} op_t;

	localparam int unsigned VALUE_W   = 32;
	localparam int unsigned DIGITS    = 10;           // decimal digits of a 32-bit value
	localparam int unsigned BCD_W     = 4 * DIGITS;
	localparam int unsigned SLOTS     = 16;           // longest character run
	localparam int unsigned BITS_STG  = 8;            // value bits consumed per stage
	localparam int unsigned CHAR_W    = 7;

	localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'h30;  // '0'
	localparam logic [CHAR_W-1:0] CHAR_UPPERA = 7'h41;  // 'A'
	localparam logic [3:0]        DEC_RADIX   = 4'd10;
	localparam logic [3:0]        DIGIT_MASK  = 4'hF;
	localparam logic [3:0]        DEC16_START = 4'd11;  // five digits, right aligned
	localparam logic [3:0]        HEX32_START = 4'd8;   // eight nibbles
	localparam logic [3:0]        BIN16_START = 4'd0;   // sixteen bits
	localparam logic [3:0]        DEC32_BASE  = 4'd6;   // ten digits, before zero strip
	localparam logic [3:0]        LAST_SLOT   = 4'd15;

	// Input transaction
	typedef struct packed {
		op_t                operation;
		logic [VALUE_W-1:0] value;
	} request_t;

	// Output transaction
	typedef struct packed {
		logic [CHAR_W-1:0] character;
		logic              last;
	} result_t;

	// Data carried down the conversion pipeline
	typedef struct packed {
		op_t                operation;
		logic [VALUE_W-1:0] value;
		logic [BCD_W-1:0]   bcd;
	} pipe_t;

	// One shift-add-3 step of binary to BCD conversion
	function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] bcd_in,
	                                             input logic bit_in);
		logic [BCD_W-1:0] adj;
		adj = bcd_in;
		for (int i = 0; i < DIGITS; i++) begin
			if (adj[4*i +: 4] >= 4'd5)
				adj[4*i +: 4] = adj[4*i +: 4] + 4'd3;
		end
		return {adj[BCD_W-2:0], bit_in};
	endfunction

	// Digit code to ASCII, hex letters in upper case
	function automatic logic [CHAR_W-1:0] to_ascii(input logic [3:0] digit);
		logic [3:0] d;
		d = digit & DIGIT_MASK;
		if (d < DEC_RADIX)
			return CHAR_ZERO + {3'b000, d};
		return CHAR_UPPERA + {3'b000, d - DEC_RADIX};
	endfunction

endpackage

>>> design/nta_dd_stage.sv
// One register stage of the binary to BCD pipeline: eight double-dabble steps.
// Depends on nta_pkg.
module nta_dd_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  nta_pkg::pipe_t    in_data,
	input  logic [7:0]        in_bits,
	input  logic              next_ready,
	output logic              ready,
	output logic              out_valid,
	output nta_pkg::pipe_t    out_data
);
	import nta_pkg::*;

	logic             valid_q;
	pipe_t            data_q;
	logic [BCD_W-1:0] bcd_d;

	// Stage moves when empty or when its contents move on
	assign ready = !valid_q || next_ready;

	// Eight shift-add-3 steps, most significant bit first
	always_comb begin
		bcd_d = in_data.bcd;
		for (int j = 0; j < BITS_STG; j++)
			bcd_d = dd_step(bcd_d, in_bits[BITS_STG-1-j]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && in_valid) begin
			data_q.operation <= in_data.operation;
			data_q.value     <= in_data.value;
			data_q.bcd       <= bcd_d;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

>>> design/nta_serializer.sv
// Character serializer: loads one converted number and emits one character per cycle.
// Depends on nta_pkg.
module nta_serializer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  nta_pkg::pipe_t    in_data,
	output logic              ready,
	output logic              strobe,
	output nta_pkg::result_t  result
);
	import nta_pkg::*;

	logic                  active_q;
	logic [3:0]            ptr_q;
	logic [SLOTS-1:0][3:0] slots_q;
	logic                  strobe_q;
	result_t               result_q;

	logic [SLOTS-1:0][3:0] slots_d;
	logic [3:0]            start_d;
	logic [3:0]            lz;
	logic                  found;
	logic                  load;
	logic                  at_last;

	assign at_last = (ptr_q == LAST_SLOT);
	assign ready   = !active_q || at_last;
	assign load    = in_valid && ready;

	// Leading zero digits of the 32-bit decimal form, at most nine
	always_comb begin
		lz    = 4'd0;
		found = 1'b0;
		for (int i = DIGITS-1; i >= 1; i--) begin
			if (!found && in_data.bcd[4*i +: 4] == 4'd0)
				lz = lz + 4'd1;
			else
				found = 1'b1;
		end
	end

	// Right-aligned digit slots and first slot to send
	always_comb begin
		slots_d = '0;
		start_d = BIN16_START;
		case (in_data.operation)
			OP_DEC32: begin
				for (int i = 0; i < DIGITS; i++)
					slots_d[4'(SLOTS-1-i)] = in_data.bcd[4*i +: 4];
				start_d = DEC32_BASE + lz;
			end
			OP_DEC16: begin
				for (int i = 0; i < 5; i++)
					slots_d[4'(SLOTS-1-i)] = in_data.bcd[4*i +: 4];
				start_d = DEC16_START;
			end
			OP_HEX32: begin
				for (int i = 0; i < 8; i++)
					slots_d[4'(SLOTS-1-i)] = in_data.value[4*i +: 4];
				start_d = HEX32_START;
			end
			OP_BIN16: begin
				for (int i = 0; i < SLOTS; i++)
					slots_d[4'(SLOTS-1-i)] = {3'b000, in_data.value[i]};
				start_d = BIN16_START;
			end
			default: begin
				slots_d = '0;
				start_d = BIN16_START;
			end
		endcase
	end

	// Control: run pointer and output strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			strobe_q <= 1'b0;
			ptr_q    <= 4'd0;
		end else begin
			strobe_q <= active_q;
			if (load) begin
				active_q <= 1'b1;
				ptr_q    <= start_d;
			end else if (active_q) begin
				if (at_last)
					active_q <= 1'b0;
				else
					ptr_q <= ptr_q + 4'd1;
			end
		end
	end

	// Payload: digit slots and output character
	always_ff @(posedge clk) begin
		if (load)
			slots_q <= slots_d;
		if (active_q) begin
			result_q.character <= to_ascii(slots_q[ptr_q]);
			result_q.last      <= at_last;
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

endmodule

>>> design/number_to_ascii_formatter.sv
// Top level of the number to ASCII formatter: conversion pipeline plus serializer.
// Depends on nta_pkg, nta_dd_stage and nta_serializer.
//
// Usage:
//   Input channel: drive request (operation, value) with start high; the
//   transaction is taken at a rising edge where start is high and busy is low.
//   Output channel: each character appears on result for exactly one cycle with
//   strobe high; result.last marks the final character of a number's run.
//   Path: a number reaches the port through the four double-dabble registers,
//   the serializer load and the result register, when the serializer is free.
//   Throughput: one character per cycle while a run is sent; a number has
//   1 to 10 characters for 32-bit decimal and 5, 8 or 16 for the other formats,
//   sent by the single character serializer. Runs follow each other with no gap.
//   Four double-dabble stages hold further numbers while a run is sent; busy
//   rises only when all of them are full.
//   Reset clears all valid bits and the strobe; nothing is emitted after reset
//   until a new transaction arrives. The receiver cannot stall the output.
module number_to_ascii_formatter (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  nta_pkg::request_t request,
	output logic              strobe,
	output nta_pkg::result_t  result
);
	import nta_pkg::*;

	localparam int unsigned STAGES = VALUE_W / BITS_STG;

	logic  [STAGES:0] valid_w;
	pipe_t [STAGES:0] data_w;
	logic  [STAGES:0] ready_w;

	// Stage input: 16-bit decimal converts only the low half
	always_comb begin
		data_w[0].operation = request.operation;
		data_w[0].value     = request.value;
		if (request.operation == OP_DEC16)
			data_w[0].value = {16'h0000, request.value[15:0]};
		data_w[0].bcd = '0;
	end
	assign valid_w[0] = start;
	assign busy       = !ready_w[0];

	// Binary to BCD pipeline, most significant byte first
	for (genvar k = 0; k < STAGES; k++) begin : g_dd
		nta_dd_stage u_stage (
			.clk        (clk),
			.arst_n     (arst_n),
			.in_valid   (valid_w[k]),
			.in_data    (data_w[k]),
			.in_bits    (data_w[k].value[VALUE_W-1-BITS_STG*k -: BITS_STG]),
			.next_ready (ready_w[k+1]),
			.ready      (ready_w[k]),
			.out_valid  (valid_w[k+1]),
			.out_data   (data_w[k+1])
		);
	end

	// Character output
	nta_serializer u_ser (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_w[STAGES]),
		.in_data  (data_w[STAGES]),
		.ready    (ready_w[STAGES]),
		.strobe   (strobe),
		.result   (result)
	);

endmodule
